// ----- rtl/rsfe_pkg.sv -----
// Package: shared types, codes and helpers of the raster solid fill engine.
`timescale 1ns / 1ps
`default_nettype none

package rsfe_pkg;

  localparam int RSFE_OFFSET_BITS = 32;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_STEP  = 1'b1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DEPTH = 2'd1;
  localparam logic [1:0] ERR_ROW   = 2'd2;

  localparam logic [1:0] REG_PIXEL_DEPTH = 2'd0;
  localparam logic [1:0] REG_BIG_ENDIAN  = 2'd1;
  localparam logic [1:0] REG_ROW_BYTES   = 2'd2;
  localparam logic [1:0] REG_ROW_COUNT   = 2'd3;

  localparam logic [5:0] DEPTH_RESET = 6'd8;
  localparam logic [5:0] TRIP_LO     = 6'd17;
  localparam logic [5:0] TRIP_HI     = 6'd24;

  typedef struct packed {
    logic        opcode;
    logic [31:0] fill_value;
  } rsfe_in_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] byte_offset;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic        last;
    logic [1:0]  error;
  } rsfe_out_t;

  typedef struct packed {
    logic [5:0]  pixel_depth;
    logic        big_endian;
    logic [15:0] row_bytes;
    logic [15:0] row_count;
    logic [15:0] per_row;
    logic [31:0] total;
  } rsfe_cfg_t;

  // x / 3 for 16-bit x: reciprocal multiply, exact over the full range
  function automatic logic [15:0] div3(input logic [15:0] x);
    logic [31:0] p;
    p = {16'b0, x} * 32'd43691;
    return {1'b0, p[31:17]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rsfe_chan_if.sv -----
// Interface: valid/ready channel carrying one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface rsfe_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rsfe_cfg.sv -----
// Configuration registers plus derived per-row triplet count and area size.
`timescale 1ns / 1ps
`default_nettype none

module rsfe_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [1:0]        index,
  input  wire logic [15:0]       wdata,
  output rsfe_pkg::rsfe_cfg_t    cfg
);
  import rsfe_pkg::*;

  rsfe_cfg_t   regs;
  logic [15:0] mul_a;
  logic [15:0] mul_b;

  // one multiplier: new operand times the other stored dimension
  always_comb begin
    if (index == REG_ROW_BYTES) begin
      mul_a = wdata;
      mul_b = regs.row_count;
    end else begin
      mul_a = regs.row_bytes;
      mul_b = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pixel_depth <= DEPTH_RESET;
      regs.big_endian  <= 1'b0;
      regs.row_bytes   <= '0;
      regs.row_count   <= '0;
      regs.per_row     <= '0;
      regs.total       <= '0;
    end else if (we) begin
      case (index)
        REG_PIXEL_DEPTH: regs.pixel_depth <= wdata[5:0];
        REG_BIG_ENDIAN:  regs.big_endian  <= wdata[0];
        REG_ROW_BYTES: begin
          regs.row_bytes <= wdata;
          regs.per_row   <= div3(wdata);
          regs.total     <= 32'(mul_a) * 32'(mul_b);
        end
        REG_ROW_COUNT: begin
          regs.row_count <= wdata;
          regs.total     <= 32'(mul_a) * 32'(mul_b);
        end
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ----- rtl/raster_solid_fill_engine_unit.sv -----
// Top level: raster solid fill engine, one command in and one write result out.
// A command's result is registered and shows on wr in the cycle after the command is accepted.
// Throughput: one command per cycle; the single output register refills in the cycle
// it is taken, so cmd.ready stays high while wr is drained every cycle.
// Config changes to row_bytes/row_count update the area size one multiply in the config block.
// Reset (rst, synchronous): depth 8, little endian, empty raster, no job, output empty.
`timescale 1ns / 1ps
`default_nettype none

module raster_solid_fill_engine_unit #(
  parameter int OFFSET_BITS = rsfe_pkg::RSFE_OFFSET_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  rsfe_chan_if.sink        cmd,
  rsfe_chan_if.source      wr
);
  import rsfe_pkg::*;

  localparam int          OUT_BITS = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam logic [31:0] OFF_MASK = {32{1'b1}} >> (32 - OUT_BITS);

  rsfe_cfg_t cfg;

  rsfe_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  logic        job_active, job_active_next;
  logic        triplet_mode, triplet_mode_next;
  logic [31:0] pattern_bytes, pattern_bytes_next;
  logic [31:0] current_offset, current_offset_next;
  logic [31:0] row_start, row_start_next;
  logic [15:0] row_index, row_index_next;
  logic [15:0] triplet_index, triplet_index_next;

  logic        out_valid;
  rsfe_out_t   out_data;
  rsfe_out_t   res;
  logic        accept;

  logic [31:0] v;
  logic [7:0]  b1, b2, b3;
  logic [31:0] rep;
  logic        depth_ok;
  logic [31:0] trip_off;
  logic [15:0] ti_inc;
  logic [15:0] ri_inc;
  logic [31:0] remain;
  logic [2:0]  cnt;
  logic [31:0] cur_inc;

  assign cmd.ready = !out_valid || wr.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign wr.valid  = out_valid;
  assign wr.data   = out_data;

  assign v = cmd.data.fill_value;

  always_comb begin
    if (cfg.big_endian) begin
      b1 = v[23:16];
      b2 = v[15:8];
      b3 = v[7:0];
    end else begin
      b1 = v[7:0];
      b2 = v[15:8];
      b3 = v[23:16];
    end
  end

  // value masked to rounded-up depth, repeated over the word; depths 0, 17 to 24 and above 32 clear depth_ok
  always_comb begin
    depth_ok = 1'b1;
    rep      = v;
    case (cfg.pixel_depth) inside
      6'd1:            rep = {32{v[0]}};
      6'd2:            rep = {16{v[1:0]}};
      [6'd3:6'd4]:     rep = {8{v[3:0]}};
      [6'd5:6'd8]:     rep = {4{v[7:0]}};
      [6'd9:6'd16]:    rep = {2{v[15:0]}};
      [6'd25:6'd32]:   rep = v;
      default:         depth_ok = 1'b0;
    endcase
  end

  assign trip_off = row_start + {14'b0, triplet_index, 1'b0} + {16'b0, triplet_index};
  assign ti_inc   = triplet_index + 16'd1;
  assign ri_inc   = row_index + 16'd1;
  assign remain   = cfg.total - current_offset;
  assign cnt      = (remain < 32'd4) ? remain[2:0] : 3'd4;
  assign cur_inc  = current_offset + {29'b0, cnt};

  always_comb begin
    res                 = '0;
    job_active_next     = job_active;
    triplet_mode_next   = triplet_mode;
    pattern_bytes_next  = pattern_bytes;
    current_offset_next = current_offset;
    row_start_next      = row_start;
    row_index_next      = row_index;
    triplet_index_next  = triplet_index;

    if (cmd.data.opcode == OP_START) begin
      job_active_next     = 1'b0;
      current_offset_next = '0;
      row_start_next      = '0;
      row_index_next      = '0;
      triplet_index_next  = '0;
      if (cfg.pixel_depth >= TRIP_LO && cfg.pixel_depth <= TRIP_HI) begin
        if (b1 == b2 && b2 == b3) begin
          triplet_mode_next  = 1'b0;
          pattern_bytes_next = {4{b1}};
          job_active_next    = cfg.total != '0;
        end else begin
          triplet_mode_next  = 1'b1;
          pattern_bytes_next = {8'h00, b3, b2, b1};
          job_active_next    = cfg.per_row != '0 && cfg.row_count != '0;
        end
        res.last = !job_active_next;
      end else if (cfg.row_bytes[1:0] != 2'b00) begin
        res.last  = 1'b1;
        res.error = ERR_ROW;
      end else if (!depth_ok) begin
        res.last  = 1'b1;
        res.error = ERR_DEPTH;
      end else begin
        // an all-equal-bytes word is unchanged by the swap
        pattern_bytes_next = cfg.big_endian ? swap32(rep) : rep;
        triplet_mode_next  = 1'b0;
        job_active_next    = cfg.total != '0;
        res.last           = !job_active_next;
      end
    end else if (job_active) begin
      if (triplet_mode) begin
        if (cfg.per_row == '0 || row_index >= cfg.row_count ||
            triplet_index >= cfg.per_row) begin
          job_active_next = 1'b0;
          res.last        = 1'b1;
        end else begin
          res.write_valid = 1'b1;
          res.byte_offset = trip_off & OFF_MASK;
          res.write_data  = {8'h00, pattern_bytes[23:0]};
          res.byte_count  = 3'd3;
          if (ti_inc >= cfg.per_row) begin
            triplet_index_next = '0;
            row_index_next     = ri_inc;
            row_start_next     = row_start + {16'b0, cfg.row_bytes};
            res.last           = ri_inc >= cfg.row_count;
          end else begin
            triplet_index_next = ti_inc;
            res.last           = row_index >= cfg.row_count;
          end
          job_active_next = !res.last;
        end
      end else begin
        if (current_offset >= cfg.total) begin
          job_active_next = 1'b0;
          res.last        = 1'b1;
        end else begin
          res.write_valid = 1'b1;
          res.byte_offset = current_offset & OFF_MASK;
          res.byte_count  = cnt;
          case (cnt)
            3'd1:    res.write_data = {24'b0, pattern_bytes[7:0]};
            3'd2:    res.write_data = {16'b0, pattern_bytes[15:0]};
            3'd3:    res.write_data = {8'b0, pattern_bytes[23:0]};
            default: res.write_data = pattern_bytes;
          endcase
          current_offset_next = cur_inc;
          res.last            = cur_inc >= cfg.total;
          job_active_next     = !res.last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_active     <= 1'b0;
      triplet_mode   <= 1'b0;
      pattern_bytes  <= '0;
      current_offset <= '0;
      row_start      <= '0;
      row_index      <= '0;
      triplet_index  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        job_active     <= job_active_next;
        triplet_mode   <= triplet_mode_next;
        pattern_bytes  <= pattern_bytes_next;
        current_offset <= current_offset_next;
        row_start      <= row_start_next;
        row_index      <= row_index_next;
        triplet_index  <= triplet_index_next;
        out_valid      <= 1'b1;
      end else if (wr.ready) begin
        out_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  // a step with no job in progress gives an empty, non-final result
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.data.opcode == OP_STEP && !job_active
    |=> !out_data.write_valid && !out_data.last)
    else $error("idle step produced a write or end marker");

  // a write carries one to four lanes and no error
  a_write_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_valid
    |-> out_data.byte_count != 3'd0 && out_data.byte_count <= 3'd4 &&
        out_data.error == ERR_NONE)
    else $error("malformed write result");

  // an error ends the job without a write
  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error != ERR_NONE
    |-> out_data.last && !out_data.write_valid && !job_active)
    else $error("error result left a job running");

  // the final result of a job leaves no job active
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> !job_active)
    else $error("job still active after final result");

endmodule

`default_nettype wire
